>>> hdl/srv_pkg.sv
// Shared types, register codes and fixed-point helpers for the Schroeder reverb.
`timescale 1ns / 1ps

package srv_pkg;

  localparam int COMB_LINE_LEN_DEF    = 600;
  localparam int ALLPASS_LINE_LEN_DEF = 300;
  localparam int NUM_COMB             = 4;
  localparam int NUM_AP               = 2;

  localparam int COMB_DLY_MIN   = 50;
  localparam int AP_DELAY_MIN   = 30;
  localparam int COMB_DLY_RST   = 600;
  localparam int AP_DELAY_RST   = 300;

  localparam logic [14:0] GAIN_MAX     = 15'd31128;
  localparam logic [14:0] DRY_GAIN_RST = 15'd32767;

  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_COMB_DLY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMB_FB    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AP_DELAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AP_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN   = 3'd5;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [17:0] wide_t;
  typedef logic signed [30:0] prod_t;

  // line clearing in progress
  typedef struct packed {
    logic comb;
    logic ap;
  } srv_clr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COMB,
    ST_AP_RD,
    ST_AP_M1,
    ST_AP_V,
    ST_AP_M2,
    ST_AP_Y,
    ST_MIX1,
    ST_MIX2
  } srv_state_t;

  function automatic wide_t ext18(input sample_t v);
    return {{2{v[15]}}, v};
  endfunction

  function automatic sample_t sat16(input wide_t v);
    sample_t r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // unsigned Q15 gain times signed sample; product fits 31 bits
  function automatic prod_t mul_q(input logic [14:0] g, input sample_t v);
    logic signed [31:0] p;
    p = $signed({1'b0, g}) * v;
    return p[30:0];
  endfunction

  function automatic logic [14:0] gain_clamp(input logic [14:0] g);
    return (g > GAIN_MAX) ? GAIN_MAX : g;
  endfunction

endpackage

>>> hdl/schroeder_reverb_q15_top.sv
// Top level of the Q15 Schroeder reverb: config block, sample sequencer and the two line RAMs.
`timescale 1ns / 1ps

//  channel | dir | handshake                    | payload
//  --------+-----+------------------------------+------------------------------
//  in      | in  | in_valid / in_stall          | sample_in  (16 bit signed)
//  out     | out | out_valid / out_stall        | sample_out (16 bit signed)
//  cfg     | in  | cfg_we (no stall)            | cfg_index (3 bit), cfg_data (15 bit)
//
//  A sample holds the sequencer after its transfer: ST_COMB for the four comb
//  read-modify-writes, ST_AP_RD to ST_AP_Y per all-pass stage, ST_MIX1 and ST_MIX2 for the
//  mix, all on the one shared 15x16 multiplier; a new sample is taken only in ST_IDLE.
//  Reset clears both RAMs; a comb delay write clears the comb RAM (4*COMB_LINE_LEN
//  entries), an all-pass delay write the all-pass RAM (2*ALLPASS_LINE_LEN entries).
//  in_stall is high during a clear, while a sample is in flight or waits on out_stall.

module schroeder_reverb_q15_top import srv_pkg::*; #(
  parameter int COMB_LINE_LEN    = COMB_LINE_LEN_DEF,
  parameter int ALLPASS_LINE_LEN = ALLPASS_LINE_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sample_t               sample_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sample_t               sample_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CLW = $clog2(COMB_LINE_LEN+1);
  localparam int ALW = $clog2(ALLPASS_LINE_LEN+1);
  localparam int CAW = $clog2(NUM_COMB*COMB_LINE_LEN);
  localparam int AAW = $clog2(NUM_AP*ALLPASS_LINE_LEN);

  logic [14:0]    comb_fb;
  logic [14:0]    ap_gain;
  logic [14:0]    wet_gain;
  logic [14:0]    dry_gain;
  logic [CLW-1:0] comb_len [NUM_COMB];
  logic [ALW-1:0] ap_len [NUM_AP];
  srv_clr_t       clr;
  logic [CAW-1:0] comb_clr_addr;
  logic [AAW-1:0] ap_clr_addr;

  // sequencer side of the RAM ports
  logic           core_comb_we;
  logic [CAW-1:0] core_comb_waddr;
  sample_t        core_comb_wdata;
  logic           comb_re;
  logic [CAW-1:0] comb_raddr;
  sample_t        comb_rdata;
  logic           core_ap_we;
  logic [AAW-1:0] core_ap_waddr;
  sample_t        core_ap_wdata;
  logic           ap_re;
  logic [AAW-1:0] ap_raddr;
  sample_t        ap_rdata;

  // RAM write ports after the clear-sweep mux
  logic           comb_we;
  logic [CAW-1:0] comb_waddr;
  sample_t        comb_wdata;
  logic           ap_we;
  logic [AAW-1:0] ap_waddr;
  sample_t        ap_wdata;

  srv_cfg #(
    .COMB_LINE_LEN    (COMB_LINE_LEN),
    .ALLPASS_LINE_LEN (ALLPASS_LINE_LEN)
  ) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .comb_fb       (comb_fb),
    .ap_gain       (ap_gain),
    .wet_gain      (wet_gain),
    .dry_gain      (dry_gain),
    .comb_len      (comb_len),
    .ap_len        (ap_len),
    .clr           (clr),
    .comb_clr_addr (comb_clr_addr),
    .ap_clr_addr   (ap_clr_addr)
  );

  srv_core #(
    .COMB_LINE_LEN    (COMB_LINE_LEN),
    .ALLPASS_LINE_LEN (ALLPASS_LINE_LEN)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .comb_fb    (comb_fb),
    .ap_gain    (ap_gain),
    .wet_gain   (wet_gain),
    .dry_gain   (dry_gain),
    .comb_len   (comb_len),
    .ap_len     (ap_len),
    .clr        (clr),
    .comb_we    (core_comb_we),
    .comb_waddr (core_comb_waddr),
    .comb_wdata (core_comb_wdata),
    .comb_re    (comb_re),
    .comb_raddr (comb_raddr),
    .comb_rdata (comb_rdata),
    .ap_we      (core_ap_we),
    .ap_waddr   (core_ap_waddr),
    .ap_wdata   (core_ap_wdata),
    .ap_re      (ap_re),
    .ap_raddr   (ap_raddr),
    .ap_rdata   (ap_rdata)
  );

  // the sweep owns the write port while it runs; the sequencer takes no new sample then
  assign comb_we    = clr.comb | core_comb_we;
  assign comb_waddr = clr.comb ? comb_clr_addr : core_comb_waddr;
  assign comb_wdata = clr.comb ? '0 : core_comb_wdata;
  assign ap_we      = clr.ap | core_ap_we;
  assign ap_waddr   = clr.ap ? ap_clr_addr : core_ap_waddr;
  assign ap_wdata   = clr.ap ? '0 : core_ap_wdata;

  // four comb lines, back to back, COMB_LINE_LEN entries each
  srv_ram #(
    .WIDTH (16),
    .DEPTH (NUM_COMB*COMB_LINE_LEN)
  ) u_comb_ram (
    .clk   (clk),
    .we    (comb_we),
    .waddr (comb_waddr),
    .wdata (comb_wdata),
    .re    (comb_re),
    .raddr (comb_raddr),
    .rdata (comb_rdata)
  );

  // two all-pass lines, ALLPASS_LINE_LEN entries each
  srv_ram #(
    .WIDTH (16),
    .DEPTH (NUM_AP*ALLPASS_LINE_LEN)
  ) u_ap_ram (
    .clk   (clk),
    .we    (ap_we),
    .waddr (ap_waddr),
    .wdata (ap_wdata),
    .re    (ap_re),
    .raddr (ap_raddr),
    .rdata (ap_rdata)
  );

endmodule

>>> hdl/srv_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module srv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/srv_cfg.sv
// Configuration registers, derived delay lengths and line clearing sweeps.
`timescale 1ns / 1ps

module srv_cfg import srv_pkg::*; #(
  parameter int COMB_LINE_LEN    = COMB_LINE_LEN_DEF,
  parameter int ALLPASS_LINE_LEN = ALLPASS_LINE_LEN_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_we,
  input  logic [CFG_IDX_W-1:0]                         cfg_index,
  input  logic [CFG_DATA_W-1:0]                        cfg_data,
  output logic [14:0]                                  comb_fb,
  output logic [14:0]                                  ap_gain,
  output logic [14:0]                                  wet_gain,
  output logic [14:0]                                  dry_gain,
  output logic [$clog2(COMB_LINE_LEN+1)-1:0]           comb_len [NUM_COMB],
  output logic [$clog2(ALLPASS_LINE_LEN+1)-1:0]        ap_len [NUM_AP],
  output srv_clr_t                                     clr,
  output logic [$clog2(NUM_COMB*COMB_LINE_LEN)-1:0]    comb_clr_addr,
  output logic [$clog2(NUM_AP*ALLPASS_LINE_LEN)-1:0]   ap_clr_addr
);

  localparam int CLW = $clog2(COMB_LINE_LEN+1);
  localparam int ALW = $clog2(ALLPASS_LINE_LEN+1);
  localparam int CAW = $clog2(NUM_COMB*COMB_LINE_LEN);
  localparam int AAW = $clog2(NUM_AP*ALLPASS_LINE_LEN);
  localparam int CRW = $clog2(5*COMB_LINE_LEN+1);
  localparam int ARW = $clog2(2*ALLPASS_LINE_LEN+1);

  localparam int CD_RST = (COMB_DLY_RST > COMB_LINE_LEN) ? COMB_LINE_LEN : COMB_DLY_RST;
  localparam int AD_RST = (AP_DELAY_RST > ALLPASS_LINE_LEN) ? ALLPASS_LINE_LEN : AP_DELAY_RST;
  localparam int CQ1_RST = CD_RST * 5 / 6;
  localparam int CQ2_RST = CD_RST * 4 / 6;
  localparam int CQ3_RST = CD_RST * 3 / 6;
  localparam int AQ_RST  = AD_RST * 2 / 3;

  localparam logic [CAW-1:0] COMB_CLR_LAST = CAW'(NUM_COMB*COMB_LINE_LEN-1);
  localparam logic [AAW-1:0] AP_CLR_LAST   = AAW'(NUM_AP*ALLPASS_LINE_LEN-1);

  logic [CLW-1:0] comb_d;
  logic [ALW-1:0] ap_d;
  logic [CLW-1:0] comb_d_next;
  logic [ALW-1:0] ap_d_next;
  logic [15:0]    cd_raw;
  logic [15:0]    ad_raw;

  // 5d, 4d, 3d reduced by repeated subtraction of 6, and 2d by 3, while the lines clear
  logic [CRW-1:0] crem [3];
  logic [CLW-1:0] cquo [3];
  logic [ARW-1:0] arem;
  logic [ALW-1:0] aquo;

  assign cd_raw = 16'(cfg_data[9:0]);
  assign ad_raw = 16'(cfg_data[8:0]);

  always_comb begin
    if (cd_raw < 16'(COMB_DLY_MIN)) begin
      comb_d_next = CLW'(COMB_DLY_MIN);
    end else if (cd_raw > 16'(COMB_LINE_LEN)) begin
      comb_d_next = CLW'(COMB_LINE_LEN);
    end else begin
      comb_d_next = cd_raw[CLW-1:0];
    end
    if (ad_raw < 16'(AP_DELAY_MIN)) begin
      ap_d_next = ALW'(AP_DELAY_MIN);
    end else if (ad_raw > 16'(ALLPASS_LINE_LEN)) begin
      ap_d_next = ALW'(ALLPASS_LINE_LEN);
    end else begin
      ap_d_next = ad_raw[ALW-1:0];
    end
  end

  assign comb_len[0] = comb_d;
  assign comb_len[1] = cquo[0];
  assign comb_len[2] = cquo[1];
  assign comb_len[3] = cquo[2];
  assign ap_len[0]   = ap_d;
  assign ap_len[1]   = aquo;

  always_ff @(posedge clk) begin
    if (rst) begin
      comb_fb       <= '0;
      ap_gain       <= '0;
      wet_gain      <= '0;
      dry_gain      <= DRY_GAIN_RST;
      comb_d        <= CLW'(CD_RST);
      ap_d          <= ALW'(AD_RST);
      cquo[0]       <= CLW'(CQ1_RST);
      cquo[1]       <= CLW'(CQ2_RST);
      cquo[2]       <= CLW'(CQ3_RST);
      aquo          <= ALW'(AQ_RST);
      crem[0]       <= '0;
      crem[1]       <= '0;
      crem[2]       <= '0;
      arem          <= '0;
      clr.comb      <= 1'b1;
      clr.ap        <= 1'b1;
      comb_clr_addr <= '0;
      ap_clr_addr   <= '0;
    end else begin
      for (int k = 0; k < 3; k++) begin
        if (crem[k] >= CRW'(6)) begin
          crem[k] <= crem[k] - CRW'(6);
          cquo[k] <= cquo[k] + CLW'(1);
        end
      end
      if (arem >= ARW'(3)) begin
        arem <= arem - ARW'(3);
        aquo <= aquo + ALW'(1);
      end

      if (clr.comb) begin
        comb_clr_addr <= comb_clr_addr + CAW'(1);
        if (comb_clr_addr == COMB_CLR_LAST) begin
          clr.comb <= 1'b0;
        end
      end
      if (clr.ap) begin
        ap_clr_addr <= ap_clr_addr + AAW'(1);
        if (ap_clr_addr == AP_CLR_LAST) begin
          clr.ap <= 1'b0;
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_COMB_DLY: begin
            comb_d        <= comb_d_next;
            crem[0]       <= CRW'(comb_d_next) * CRW'(5);
            crem[1]       <= CRW'(comb_d_next) * CRW'(4);
            crem[2]       <= CRW'(comb_d_next) * CRW'(3);
            cquo[0]       <= '0;
            cquo[1]       <= '0;
            cquo[2]       <= '0;
            clr.comb      <= 1'b1;
            comb_clr_addr <= '0;
          end
          REG_COMB_FB:  comb_fb <= gain_clamp(cfg_data[14:0]);
          REG_AP_DELAY: begin
            ap_d        <= ap_d_next;
            arem        <= ARW'(ap_d_next) * ARW'(2);
            aquo        <= '0;
            clr.ap      <= 1'b1;
            ap_clr_addr <= '0;
          end
          REG_AP_GAIN:  ap_gain  <= gain_clamp(cfg_data[14:0]);
          REG_WET_GAIN: wet_gain <= cfg_data[14:0];
          REG_DRY_GAIN: dry_gain <= cfg_data[14:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> hdl/srv_core.sv
// Per-sample sequencer: comb and all-pass read-modify-write over the line RAMs, then the mix.
`timescale 1ns / 1ps

module srv_core import srv_pkg::*; #(
  parameter int COMB_LINE_LEN    = COMB_LINE_LEN_DEF,
  parameter int ALLPASS_LINE_LEN = ALLPASS_LINE_LEN_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  sample_t                                     sample_in,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output sample_t                                     sample_out,
  input  logic [14:0]                                 comb_fb,
  input  logic [14:0]                                 ap_gain,
  input  logic [14:0]                                 wet_gain,
  input  logic [14:0]                                 dry_gain,
  input  logic [$clog2(COMB_LINE_LEN+1)-1:0]          comb_len [NUM_COMB],
  input  logic [$clog2(ALLPASS_LINE_LEN+1)-1:0]       ap_len [NUM_AP],
  input  srv_clr_t                                    clr,
  output logic                                        comb_we,
  output logic [$clog2(NUM_COMB*COMB_LINE_LEN)-1:0]   comb_waddr,
  output sample_t                                     comb_wdata,
  output logic                                        comb_re,
  output logic [$clog2(NUM_COMB*COMB_LINE_LEN)-1:0]   comb_raddr,
  input  sample_t                                     comb_rdata,
  output logic                                        ap_we,
  output logic [$clog2(NUM_AP*ALLPASS_LINE_LEN)-1:0]  ap_waddr,
  output sample_t                                     ap_wdata,
  output logic                                        ap_re,
  output logic [$clog2(NUM_AP*ALLPASS_LINE_LEN)-1:0]  ap_raddr,
  input  sample_t                                     ap_rdata
);

  localparam int CLW = $clog2(COMB_LINE_LEN+1);
  localparam int ALW = $clog2(ALLPASS_LINE_LEN+1);
  localparam int CPW = $clog2(COMB_LINE_LEN);
  localparam int APW = $clog2(ALLPASS_LINE_LEN);
  localparam int CAW = $clog2(NUM_COMB*COMB_LINE_LEN);
  localparam int AAW = $clog2(NUM_AP*ALLPASS_LINE_LEN);

  localparam logic [2:0] COMB_LAST = 3'd5;

  srv_state_t state, state_next;

  logic [2:0]     cnt;
  logic           stage;
  sample_t        x;
  wide_t          acc;
  sample_t        sig;
  sample_t        tap;
  sample_t        v;
  sample_t        dry_term;
  prod_t          prod;
  logic [CPW-1:0] comb_pos [NUM_COMB];
  logic [APW-1:0] ap_pos [NUM_AP];
  logic [CAW-1:0] cw_addr1;
  logic [CAW-1:0] cw_addr2;
  logic [AAW-1:0] ap_addr;

  logic           accept;
  logic           out_free;
  logic [1:0]     cidx;
  logic [CAW-1:0] comb_base;
  logic [CAW-1:0] comb_addr_cur;
  logic [CPW-1:0] comb_pos_inc;
  logic [CLW-1:0] comb_pos_p1;
  logic [AAW-1:0] ap_addr_cur;
  logic [APW-1:0] ap_pos_inc;
  logic [ALW-1:0] ap_pos_p1;
  sample_t        att;
  sample_t        prod_q;
  sample_t        v_next;
  sample_t        y_next;
  sample_t        sig_comb;
  sample_t        mix;
  wide_t          acc_adj;
  wide_t          acc_q;

  logic           mul_en;
  logic [14:0]    mul_g;
  sample_t        mul_v;

  assign accept   = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;
  assign in_stall = (state != ST_IDLE) | clr.comb | clr.ap;

  assign cidx   = cnt[1:0];
  assign prod_q = prod[30:15];
  assign att    = x >>> 2;

  always_comb begin
    case (cidx)
      2'd0:    comb_base = '0;
      2'd1:    comb_base = CAW'(COMB_LINE_LEN);
      2'd2:    comb_base = CAW'(2*COMB_LINE_LEN);
      default: comb_base = CAW'(3*COMB_LINE_LEN);
    endcase
  end

  assign comb_addr_cur = comb_base + CAW'(comb_pos[cidx]);
  assign comb_pos_p1   = CLW'(comb_pos[cidx]) + CLW'(1);
  assign comb_pos_inc  = (comb_pos_p1 >= comb_len[cidx]) ? '0 : comb_pos_p1[CPW-1:0];

  assign ap_addr_cur = (stage ? AAW'(ALLPASS_LINE_LEN) : '0) + AAW'(ap_pos[stage]);
  assign ap_pos_p1   = ALW'(ap_pos[stage]) + ALW'(1);
  assign ap_pos_inc  = (ap_pos_p1 >= ap_len[stage]) ? '0 : ap_pos_p1[APW-1:0];

  // comb sum / 4, truncating toward zero
  assign acc_adj  = acc + (acc[17] ? 18'sd3 : 18'sd0);
  assign acc_q    = acc_adj >>> 2;
  assign sig_comb = sat16(acc_q);

  assign v_next = sat16(ext18(sig) + ext18(prod_q));
  assign y_next = sat16(ext18(tap) - ext18(prod_q));
  assign mix    = sat16(ext18(dry_term) + ext18(prod_q));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_COMB;
      ST_COMB:  if (cnt == COMB_LAST) state_next = ST_AP_RD;
      ST_AP_RD: state_next = ST_AP_M1;
      ST_AP_M1: state_next = ST_AP_V;
      ST_AP_V:  state_next = ST_AP_M2;
      ST_AP_M2: state_next = ST_AP_Y;
      ST_AP_Y:  state_next = stage ? ST_MIX1 : ST_AP_RD;
      ST_MIX1:  state_next = ST_MIX2;
      ST_MIX2:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // comb phase is a 6-step pipeline: read comb n, multiply comb n-1, write comb n-2
  always_comb begin
    comb_re    = 1'b0;
    comb_raddr = comb_addr_cur;
    comb_we    = 1'b0;
    comb_waddr = cw_addr2;
    comb_wdata = sat16(ext18(att) + ext18(prod_q));
    ap_re      = 1'b0;
    ap_raddr   = ap_addr_cur;
    ap_we      = 1'b0;
    ap_waddr   = ap_addr;
    ap_wdata   = v_next;
    mul_en     = 1'b0;
    mul_g      = comb_fb;
    mul_v      = comb_rdata;
    case (state)
      ST_COMB: begin
        comb_re = ~cnt[2];
        if (cnt inside {[3'd1:3'd4]}) begin
          mul_en = 1'b1;
        end
        if (cnt >= 3'd2) begin
          comb_we = 1'b1;
        end
        if (cnt == COMB_LAST) begin
          mul_en = 1'b1;
          mul_g  = dry_gain;
          mul_v  = x;
        end
      end
      ST_AP_RD: ap_re = 1'b1;
      ST_AP_M1: begin
        mul_en = 1'b1;
        mul_g  = ap_gain;
        mul_v  = ap_rdata;
      end
      ST_AP_V: ap_we = 1'b1;
      ST_AP_M2: begin
        mul_en = 1'b1;
        mul_g  = ap_gain;
        mul_v  = v;
      end
      ST_MIX1: begin
        mul_en = 1'b1;
        mul_g  = wet_gain;
        mul_v  = sig;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      stage     <= 1'b0;
      for (int k = 0; k < NUM_COMB; k++) comb_pos[k] <= '0;
      for (int k = 0; k < NUM_AP; k++) ap_pos[k] <= '0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (clr.comb) begin
        for (int k = 0; k < NUM_COMB; k++) comb_pos[k] <= '0;
      end
      if (clr.ap) begin
        for (int k = 0; k < NUM_AP; k++) ap_pos[k] <= '0;
      end
      if (mul_en) begin
        prod <= mul_q(mul_g, mul_v);
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            x     <= sample_in;
            acc   <= '0;
            cnt   <= '0;
            stage <= 1'b0;
          end
        end
        ST_COMB: begin
          cnt      <= cnt + 3'd1;
          cw_addr1 <= comb_addr_cur;
          cw_addr2 <= cw_addr1;
          if (!cnt[2]) begin
            comb_pos[cidx] <= comb_pos_inc;
          end
          if (cnt inside {[3'd1:3'd4]}) begin
            acc <= acc + ext18(comb_rdata);
          end
          if (cnt == COMB_LAST) begin
            sig <= sig_comb;
          end
        end
        ST_AP_RD: begin
          ap_pos[stage] <= ap_pos_inc;
          ap_addr       <= ap_addr_cur;
          if (!stage) begin
            dry_term <= prod_q;
          end
        end
        ST_AP_M1: tap <= ap_rdata;
        ST_AP_V:  v <= v_next;
        ST_AP_Y: begin
          sig   <= y_next;
          stage <= 1'b1;
        end
        ST_MIX2: begin
          if (out_free) begin
            sample_out <= mix;
            out_valid  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> tb/sv/tb_schroeder_reverb_q15_top.sv
// Self-checking testbench for the Q15 Schroeder reverb top level.
`timescale 1ns / 1ps

module tb_schroeder_reverb_q15_top;
  import srv_pkg::*;

  // Register indexes the block does not decode; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam int          SETTLE_CYCLES = 40;
  localparam int          HOLD_CYCLES   = 400;         // long output hold-off
  localparam int unsigned LIMIT_NS      = 10_000_000;  // far beyond the slowest clean run

  // idling modes, in the order they are run
  localparam int IDLE_SEND_LIGHT = 0;
  localparam int IDLE_RECV_LIGHT = 1;
  localparam int IDLE_NONE       = 2;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  sample_t               sample_in;
  logic                  out_valid;
  logic                  out_stall;
  sample_t               sample_out;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  schroeder_reverb_q15_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the delay lines, pointers and gains.
  // ---------------------------------------------------------------------------
  sample_t     comb_line [NUM_COMB][COMB_LINE_LEN_DEF];
  logic [9:0]  comb_pos  [NUM_COMB];
  logic [9:0]  comb_len  [NUM_COMB];
  sample_t     ap_line   [NUM_AP][ALLPASS_LINE_LEN_DEF];
  logic [8:0]  ap_pos    [NUM_AP];
  logic [8:0]  ap_len    [NUM_AP];
  logic [14:0] g_comb, g_ap, g_wet, g_dry;

  sample_t pending_mix[$];   // predicted sample_out values, oldest first
  sample_t want;
  int      mismatches;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int hold_left;

  function automatic int clip16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Q15 gain times sample; >>> on a signed int floors, as the datapath does
  function automatic int q15_scale(input logic [14:0] g, input int v);
    int gi;
    gi = int'(g);
    return (gi * v) >>> 15;
  endfunction

  task automatic model_clear_combs(input logic [9:0] req);
    int d, i, k;
    d = int'(req);
    if (d < COMB_DLY_MIN) d = COMB_DLY_MIN;
    if (d > COMB_LINE_LEN_DEF) d = COMB_LINE_LEN_DEF;
    comb_len[0] = 10'(d);
    comb_len[1] = 10'((d * 5) / 6);
    comb_len[2] = 10'((d * 4) / 6);
    comb_len[3] = 10'((d * 3) / 6);
    for (i = 0; i < NUM_COMB; i++) begin
      comb_pos[i] = '0;
      for (k = 0; k < COMB_LINE_LEN_DEF; k++) comb_line[i][k] = '0;
    end
  endtask

  task automatic model_clear_allpass(input logic [8:0] req);
    int d, i, k;
    d = int'(req);
    if (d < AP_DELAY_MIN) d = AP_DELAY_MIN;
    if (d > ALLPASS_LINE_LEN_DEF) d = ALLPASS_LINE_LEN_DEF;
    ap_len[0] = 9'(d);
    ap_len[1] = 9'((d * 2) / 3);
    for (i = 0; i < NUM_AP; i++) begin
      ap_pos[i] = '0;
      for (k = 0; k < ALLPASS_LINE_LEN_DEF; k++) ap_line[i][k] = '0;
    end
  endtask

  task automatic model_reset();
    g_comb = '0;
    g_ap   = '0;
    g_wet  = '0;
    g_dry  = DRY_GAIN_RST;
    model_clear_combs(10'(COMB_DLY_RST));
    model_clear_allpass(9'(AP_DELAY_RST));
  endtask

  task automatic model_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_COMB_DLY:   model_clear_combs(val[9:0]);
      REG_COMB_FB:    g_comb = (val > GAIN_MAX) ? GAIN_MAX : val;
      REG_AP_DELAY:   model_clear_allpass(val[8:0]);
      REG_AP_GAIN:    g_ap = (val > GAIN_MAX) ? GAIN_MAX : val;
      REG_WET_GAIN:   g_wet = val;
      REG_DRY_GAIN:   g_dry = val;
      default: ;
    endcase
  endtask

  // One sample through the four combs, the two all-pass stages and the mix.
  function automatic sample_t reverb_predict(input sample_t x);
    int xi, att, acc, tap, sig, v, y, mix, i;
    xi  = int'(x);
    att = xi >>> 2;
    acc = 0;
    for (i = 0; i < NUM_COMB; i++) begin
      tap = int'(comb_line[i][comb_pos[i]]);
      acc += tap;
      comb_line[i][comb_pos[i]] = sample_t'(clip16(att + q15_scale(g_comb, tap)));
      comb_pos[i] = (comb_pos[i] + 1 >= comb_len[i]) ? '0 : comb_pos[i] + 1'b1;
    end
    sig = clip16(acc / NUM_COMB);   // truncates toward zero
    for (i = 0; i < NUM_AP; i++) begin
      tap = int'(ap_line[i][ap_pos[i]]);
      v   = clip16(sig + q15_scale(g_ap, tap));
      y   = clip16(tap - q15_scale(g_ap, v));
      ap_line[i][ap_pos[i]] = sample_t'(v);
      ap_pos[i] = (ap_pos[i] + 1 >= ap_len[i]) ? '0 : ap_pos[i] + 1'b1;
      sig = y;
    end
    mix = clip16(q15_scale(g_dry, xi) + q15_scale(g_wet, sig));
    return mix[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: stall driver and result checker.
  // ---------------------------------------------------------------------------

  // out_stall changes on the falling edge. A hold request pins it high until
  // hold_left, counted down here, runs out, so the block backs up into in_stall.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Every output transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_mix.size() == 0) begin
        $display("%0t ns: sample_out %0d with no sample outstanding", $time, sample_out);
        mismatches++;
      end else begin
        want = pending_mix.pop_front();
        if (sample_out !== want) begin
          $display("%0t ns: sample_out mismatch, expected %0d, got %0d",
                   $time, want, sample_out);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side helpers.
  // ---------------------------------------------------------------------------

  task automatic set_idling(input int mode);
    case (mode)
      IDLE_SEND_LIGHT: begin
        send_idle_pct = 7;
        recv_idle_pct = 53;
      end
      IDLE_RECV_LIGHT: begin
        send_idle_pct = 53;
        recv_idle_pct = 7;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Offer one sample; returns right after the transfer edge with valid still
  // high, so back-to-back calls keep valid up without a glitch.
  task automatic play_sample(input sample_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_mix.push_back(reverb_predict(s));
  endtask

  // Stop offering and wait until every predicted sample has come out.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk);
  endtask

  // in_stall stays high while the block sweeps its RAMs after reset or a delay write.
  task automatic wait_ready();
    repeat (2) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    model_write(idx, val);
    wait_ready();
  endtask

  task automatic write_all(input logic [14:0] cd, input logic [14:0] cg, input logic [14:0] ad,
                           input logic [14:0] ag, input logic [14:0] wet, input logic [14:0] dry);
    write_reg(REG_COMB_DLY, cd);
    write_reg(REG_COMB_FB, cg);
    write_reg(REG_AP_DELAY, ad);
    write_reg(REG_AP_GAIN, ag);
    write_reg(REG_WET_GAIN, wet);
    write_reg(REG_DRY_GAIN, dry);
  endtask

  // mostly full-range noise, with extremes and quiet values mixed in
  function automatic sample_t random_sample();
    sample_t s;
    case ($urandom_range(9))
      0:       s = 16'sh7fff;
      1:       s = 16'sh8000;
      2, 3:    s = sample_t'(int'($urandom_range(511)) - 256);
      default: s = sample_t'($urandom);
    endcase
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset settings: dry at full scale, wet at zero, so out is x scaled by 32767/32768.
  task automatic test_reset_defaults();
    play_sample(16'sh7fff);
    play_sample(16'sh8000);
    play_sample(16'sh0000);
    play_sample(16'sh0001);
    play_sample(16'shffff);
    play_sample(16'sh5555);
    play_sample(16'shaaaa);
    drain();
  endtask

  // Out-of-range and masked register values, spare indexes, then full-scale
  // input with every gain at maximum to drive every stage into saturation.
  task automatic test_register_extremes();
    int n;
    write_reg(REG_SPARE_6, 15'h7fff);
    write_reg(REG_SPARE_7, 15'h0000);
    // comb delay 0x414 keeps only 20 in its 10 bits, below the floor of 50;
    // all-pass delay 0x200 keeps 0 in its 9 bits, below the floor of 30
    write_all(15'h0414, 15'h7fff, 15'h0200, 15'h7fff, 15'h7fff, 15'h7fff);
    for (n = 0; n < 8; n++) play_sample(16'sh7fff);
    for (n = 0; n < 8; n++) play_sample(16'sh8000);
    drain();
  endtask

  // Six settings: one with the longest lines, one fully random, the rest short
  // so that the feedback paths wrap many times. Loud runs push the combs into clipping.
  task automatic test_random_settings();
    int      ph, n, count, run_left;
    sample_t run_val, s;
    for (ph = 0; ph < 6; ph++) begin
      set_idling(ph / 2);
      case (ph)
        0:       write_all(15'd600, GAIN_MAX, 15'd300, 15'd20000, 15'h7fff, 15'd0);
        2:       write_all(15'd50, 15'd0, 15'd30, 15'd0, 15'($urandom_range(32767)), 15'h7fff);
        4:       write_all(15'($urandom_range(32767)), 15'($urandom_range(32767)),
                           15'($urandom_range(32767)), 15'($urandom_range(32767)),
                           15'($urandom_range(32767)), 15'($urandom_range(32767)));
        3:       write_all(15'($urandom_range(60)), 15'($urandom_range(32767)),
                           15'($urandom_range(45)), 15'($urandom_range(32767)),
                           15'($urandom_range(32767)), 15'($urandom_range(32767)));
        default: write_all(15'($urandom_range(120, 50)), 15'($urandom_range(32767, 24000)),
                           15'($urandom_range(60, 30)), 15'($urandom_range(32767, 16000)),
                           15'($urandom_range(32767)), 15'($urandom_range(32767)));
      endcase
      // the longest setting needs enough samples to wrap the shorter lines
      count    = (ph == 0) ? 300 : 70;
      run_left = 0;
      for (n = 0; n < count; n++) begin
        if (run_left == 0 && $urandom_range(19) == 0) begin
          run_left    = $urandom_range(30, 10);
          run_val     = sample_t'($urandom);
          run_val[14] = ~run_val[15];   // magnitude at least half scale
        end
        if (run_left > 0) begin
          s = run_val;
          run_left--;
        end else begin
          s = random_sample();
        end
        play_sample(s);
      end
      drain();
    end
  endtask

  // Receiver holds off for a long stretch while samples keep coming, so the
  // output register and the sequencer fill and in_stall rises.
  task automatic test_output_hold();
    int n;
    hold_req = 1'b1;
    for (n = 0; n < 12; n++) play_sample(random_sample());
    drain();
  endtask

  // Sender stops until the block has fully drained, then resumes.
  task automatic test_sender_pause();
    int n;
    for (n = 0; n < 8; n++) play_sample(random_sample());
    drain();
    for (n = 0; n < 8; n++) play_sample(random_sample());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    sample_in  = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    hold_req   = 1'b0;
    mismatches = 0;
    set_idling(IDLE_SEND_LIGHT);
    model_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait_ready();   // post-reset comb and all-pass sweep

    test_reset_defaults();
    test_register_extremes();
    test_random_settings();
    set_idling(IDLE_NONE);
    test_output_hold();
    test_sender_pause();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("schroeder_reverb_q15_top verification clean");
    end else begin
      $display("schroeder_reverb_q15_top verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("schroeder_reverb_q15_top verification failed");
    $finish;
  end

endmodule

>>> schroeder_reverb_q15_top.f
hdl/srv_pkg.sv
hdl/srv_ram.sv
hdl/srv_cfg.sv
hdl/srv_core.sv
hdl/schroeder_reverb_q15_top.sv
tb/sv/tb_schroeder_reverb_q15_top.sv
